@@ src/cds_pkg.sv @@
// Shared constants and types for the C-SCAN disk scheduler.
// No dependencies; imported by every module of the block.
package cds_pkg;

	localparam int MAX_REQ = 8;
	localparam int CNT_W   = $clog2(MAX_REQ + 1);
	localparam int IDX_W   = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;
	localparam int TRACK_W = 16;
	localparam int SEEK_W  = 18;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 40;
	localparam logic [TRACK_W-1:0] TOP_TRACK_RST = 16'd199;

	typedef enum logic [1:0] {
		SEL_CUR,
		SEL_TOP,
		SEL_ZERO
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      clr_ptr;
		logic      inc_ptr;
		logic      emit;
		emit_sel_t sel;
		logic      last;
		logic      end_batch;
	} cds_cmd_t;

	typedef struct packed {
		logic at_end;
		logic up_hit;
		logic nd_zero;
		logic down_last;
		logic slot_free;
	} cds_stat_t;

endpackage

@@ src/cscan_disk_scheduler.sv @@
// Top level of the C-SCAN disk scheduler: stream ports, config write port.
// Depends on cds_pkg, cds_ctrl and cds_datapath.
//
// Usage:
//  Requests enter on the s_axis channel, one per cycle while s_axis_tready is
//  high. The first request of a batch also supplies the start head position;
//  s_axis_tlast closes the batch. Up to MAX_REQ requests are kept (sorted on
//  entry), further ones are dropped but a tlast still ends the batch.
//  After the closing request the block stops taking requests and emits the
//  service order on m_axis: requests above the head ascending, top track,
//  track 0, requests below the head ascending. m_axis_tlast marks the final
//  result, which also carries the total seek distance.
//  Emission walks the sorted row once for the upward sweep, then emits the
//  top track and track 0, then one result per downward request; any
//  receiver stall lengthens the batch.
//  A receiver stall holds the output register and pauses emission; entries not above the head are still skipped.
//  Reset clears the batch and the output valid flag and sets top_track to 199.
//  top_track is written by cfg_we/cfg_wdata and is used when a batch ends.
module cscan_disk_scheduler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cds_pkg::TRACK_W-1:0]  cfg_wdata,     // top_track
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [cds_pkg::S_DATA_W-1:0] s_axis_tdata,  // track[15:0], start_head[31:16]
	input  logic                         s_axis_tlast,  // batch_last
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [cds_pkg::M_DATA_W-1:0] m_axis_tdata,  // service_track[15:0], total_seek[33:16], zero pad
	output logic                         m_axis_tlast   // seq_last
);
	import cds_pkg::*;

	cds_cmd_t           cmd;
	cds_stat_t          stat;
	logic [TRACK_W-1:0] out_track;
	logic [SEEK_W-1:0]  out_seek;

	cds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cds_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_track  (s_axis_tdata[TRACK_W-1:0]),
		.in_head   (s_axis_tdata[2*TRACK_W-1:TRACK_W]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_track (out_track),
		.out_seek  (out_seek),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {(M_DATA_W - TRACK_W - SEEK_W)'(0), out_seek, out_track};

endmodule

@@ src/cds_datapath.sv @@
// Datapath: sorted request row (insertion on load), head and top_track registers,
// scan pointer, seek accumulator and output register. Depends on cds_pkg.
module cds_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cds_pkg::cds_cmd_t          cmd,
	output cds_pkg::cds_stat_t         stat,
	input  logic [cds_pkg::TRACK_W-1:0] in_track,
	input  logic [cds_pkg::TRACK_W-1:0] in_head,
	input  logic                       cfg_we,
	input  logic [cds_pkg::TRACK_W-1:0] cfg_wdata,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [cds_pkg::TRACK_W-1:0] out_track,
	output logic [cds_pkg::SEEK_W-1:0]  out_seek,
	output logic                       out_last
);
	import cds_pkg::*;

	logic [TRACK_W-1:0] e_q [MAX_REQ];
	logic [TRACK_W-1:0] e_d [MAX_REQ];
	logic [MAX_REQ:0]   gt;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   nd;
	logic [TRACK_W-1:0] head_q;
	logic [TRACK_W-1:0] top_q;
	logic [SEEK_W-1:0]  seek_q;
	logic [TRACK_W-1:0] cur;
	logic [TRACK_W-1:0] cur_c;
	logic [TRACK_W-1:0] val;
	logic [SEEK_W-1:0]  term;
	logic [SEEK_W-1:0]  absdiff;
	logic               out_valid_q;
	logic [TRACK_W-1:0] out_track_q;
	logic [SEEK_W-1:0]  out_seek_q;
	logic               out_last_q;

	// insertion into the ascending row
	always_comb begin
		gt[0] = 1'b0;
		for (int i = 0; i < MAX_REQ; i++) begin
			gt[i+1] = (CNT_W'(i) < count_q) && (e_q[i] > in_track);
		end
		for (int i = 0; i < MAX_REQ; i++) begin
			e_d[i] = e_q[i];
			if (gt[i+1] || (CNT_W'(i) == count_q)) begin
				e_d[i] = gt[i] ? e_q[(i > 0) ? i - 1 : 0] : in_track;
			end
		end
	end

	// entries below head after clamping form a prefix of the row
	always_comb begin
		nd = '0;
		for (int i = 0; i < MAX_REQ; i++) begin
			if ((CNT_W'(i) < count_q) && (((e_q[i] > top_q) ? top_q : e_q[i]) < head_q)) begin
				nd = nd + CNT_W'(1);
			end
		end
	end

	assign cur     = e_q[ptr_q[IDX_W-1:0]];
	assign cur_c   = (cur > top_q) ? top_q : cur;
	assign absdiff = (top_q >= head_q) ? SEEK_W'(top_q - head_q) : SEEK_W'(head_q - top_q);

	always_comb begin
		case (cmd.sel)
			SEL_CUR: begin
				val  = cur_c;
				term = SEEK_W'(cur_c);
			end
			SEL_TOP: begin
				val  = top_q;
				term = '0;
			end
			default: begin
				val  = '0;
				term = SEEK_W'(top_q);
			end
		endcase
	end

	assign stat.at_end    = (ptr_q == count_q);
	assign stat.up_hit    = (cur_c > head_q);
	assign stat.nd_zero   = (nd == '0);
	assign stat.down_last = ((ptr_q + CNT_W'(1)) == nd);
	assign stat.slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < CNT_W'(MAX_REQ))) begin
			for (int i = 0; i < MAX_REQ; i++) begin
				e_q[i] <= e_d[i];
			end
		end
		if (cmd.emit) begin
			out_track_q <= val;
			out_seek_q  <= cmd.last ? (seek_q + term) : '0;
			out_last_q  <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			head_q      <= '0;
			top_q       <= TOP_TRACK_RST;
			ptr_q       <= '0;
			seek_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				top_q <= cfg_wdata;
			end
			if (cmd.load) begin
				if (count_q == '0) begin
					head_q <= in_head;
				end
				if (count_q < CNT_W'(MAX_REQ)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.end_batch) begin
				count_q <= '0;
			end
			if (cmd.clr_ptr) begin
				ptr_q <= '0;
			end else if (cmd.inc_ptr) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			// downward sweep from 0 only adds its highest track, taken on the last result
			if (cmd.emit && (cmd.sel != SEL_CUR)) begin
				seek_q <= (cmd.sel == SEL_TOP) ? absdiff : (seek_q + term);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_track = out_track_q;
	assign out_seek  = out_seek_q;
	assign out_last  = out_last_q;

endmodule

@@ src/cds_ctrl.sv @@
// Controller: load phase, then upward scan, top track, track 0, downward scan.
// Depends on cds_pkg; drives cds_datapath through cds_cmd_t.
module cds_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	input  cds_pkg::cds_stat_t stat,
	output cds_pkg::cds_cmd_t  cmd
);
	import cds_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_UP,
		ST_TOP,
		ST_ZERO,
		ST_DOWN
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_LOAD);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sel = SEL_CUR;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.clr_ptr = 1'b1;
						state_d     = ST_UP;
					end
				end
			end
			ST_UP: begin
				if (stat.at_end) begin
					state_d = ST_TOP;
				end else if (!stat.up_hit) begin
					cmd.inc_ptr = 1'b1;
				end else if (stat.slot_free) begin
					cmd.inc_ptr = 1'b1;
					cmd.emit    = 1'b1;
				end
			end
			ST_TOP: begin
				cmd.sel = SEL_TOP;
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_ZERO;
				end
			end
			ST_ZERO: begin
				cmd.sel = SEL_ZERO;
				if (stat.slot_free) begin
					cmd.emit    = 1'b1;
					cmd.last    = stat.nd_zero;
					cmd.clr_ptr = 1'b1;
					if (stat.nd_zero) begin
						cmd.end_batch = 1'b1;
						state_d       = ST_LOAD;
					end else begin
						state_d = ST_DOWN;
					end
				end
			end
			ST_DOWN: begin
				if (stat.slot_free) begin
					cmd.emit    = 1'b1;
					cmd.inc_ptr = 1'b1;
					cmd.last    = stat.down_last;
					if (stat.down_last) begin
						cmd.end_batch = 1'b1;
						state_d       = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/cds_checker.sv @@
// Port-level checks for cscan_disk_scheduler, attached by bind.
// Depends on cds_pkg.
module cds_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         s_axis_tlast,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [cds_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic                         m_axis_tlast
);
	import cds_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_closed: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("request taken right after batch end");

	a_seek_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[TRACK_W+SEEK_W-1:TRACK_W] == '0)
		else $error("seek total on non-final result");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[M_DATA_W-1:TRACK_W+SEEK_W] == '0)
		else $error("nonzero pad bits");

endmodule

bind cscan_disk_scheduler cds_checker u_cds_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for cscan_disk_scheduler: directed and random request batches.
// A scoreboard class predicts the C-SCAN service order; depends on cds_pkg and the RTL.

typedef struct {
	bit [15:0] trk;
	bit [17:0] seek;
	bit        last;
} visit_t;

class cscan_scoreboard;
	bit [15:0] req_buf[cds_pkg::MAX_REQ];
	int        req_count;
	bit [15:0] head;
	bit        open;
	bit [15:0] top;
	visit_t    expected[$];
	int        errors;

	function new();
		req_count = 0;
		head = 0;
		open = 0;
		top = cds_pkg::TOP_TRACK_RST;
		errors = 0;
	endfunction

	function void set_top(bit [15:0] v);
		top = v;
	endfunction

	function int pending();
		return expected.size();
	endfunction

	function int unsigned gap(bit [15:0] a, bit [15:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// note one accepted request; a closing request yields the whole service order
	function void note_request(bit [15:0] trk, bit [15:0] hd, bit last);
		bit [15:0]   up_q[$];
		bit [15:0]   down_q[$];
		bit [15:0]   order[$];
		bit [15:0]   t;
		bit [15:0]   pos;
		int unsigned seek_sum;
		visit_t      v;
		if (!open) begin
			head = hd;
			req_count = 0;
			open = 1;
		end
		if (req_count < cds_pkg::MAX_REQ) begin
			req_buf[req_count] = trk;
			req_count++;
		end
		if (!last)
			return;
		for (int i = 0; i < req_count; i++) begin
			t = (req_buf[i] > top) ? top : req_buf[i];
			if (t > head)
				up_q.push_back(t);
			else if (t < head)
				down_q.push_back(t);
		end
		up_q.sort();
		down_q.sort();
		seek_sum = 0;
		pos = head;
		foreach (up_q[i]) begin
			seek_sum += gap(up_q[i], pos);
			pos = up_q[i];
			order.push_back(up_q[i]);
		end
		seek_sum += gap(top, pos);
		order.push_back(top);
		// return jump counts as a full sweep
		seek_sum += top;
		order.push_back(16'd0);
		pos = 0;
		foreach (down_q[i]) begin
			seek_sum += gap(down_q[i], pos);
			pos = down_q[i];
			order.push_back(down_q[i]);
		end
		foreach (order[i]) begin
			v.trk = order[i];
			v.last = (i == order.size() - 1);
			v.seek = v.last ? seek_sum[17:0] : 18'd0;
			expected.push_back(v);
		end
		open = 0;
		req_count = 0;
	endfunction

	function void check(bit [15:0] trk, bit [17:0] seek, bit last);
		visit_t e;
		if (expected.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t unexpected result: track %0d seek %0d last %0b",
					$realtime, trk, seek, last);
			return;
		end
		e = expected.pop_front();
		if (e.trk != trk || e.seek != seek || e.last != last) begin
			errors++;
			if (errors <= 10)
				$display("%0t mismatch: expected track %0d seek %0d last %0b, got track %0d seek %0d last %0b",
					$realtime, e.trk, e.seek, e.last, trk, seek, last);
		end
	endfunction
endclass

module tb_top;

	localparam int IDLE_LIMIT = 5000;
	localparam int PHASE_REQS = 55;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [cds_pkg::TRACK_W-1:0]  cfg_wdata;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [cds_pkg::S_DATA_W-1:0] s_axis_tdata;
	logic                         s_axis_tlast;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	logic [cds_pkg::M_DATA_W-1:0] m_axis_tdata;
	logic                         m_axis_tlast;

	cscan_scoreboard sb;
	int burst_left;
	bit steady;
	int phase_reqs;
	int ready_mode;
	int mode_left;
	int idle_cycles;

	cscan_disk_scheduler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send_request(bit [15:0] trk, bit [15:0] hd, bit last);
		int pause;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			pause = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (pause > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (pause) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {hd, trk};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(trk, hd, last);
		phase_reqs++;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_top(bit [15:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_top(v);
	endtask

	task automatic random_batch();
		int n;
		int k;
		bit [15:0] hd;
		bit [15:0] trk;
		bit [15:0] top;
		top = sb.top;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
		case ($urandom_range(0, 9))
			0: hd = 16'($urandom);
			1: hd = top;
			2: hd = 16'd0;
			default: hd = 16'($urandom_range(0, top));
		endcase
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			case (k)
				0: trk = 16'($urandom);
				1: trk = hd;
				2: trk = top;
				3: trk = 16'd0;
				default: trk = 16'($urandom_range(0, top));
			endcase
			// start head is ignored after the first request; randomize it anyway
			send_request(trk, (i == 0) ? hd : 16'($urandom), i == n - 1);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata[15:0], m_axis_tdata[33:16], m_axis_tlast);
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 120);
		end else begin
			mode_left--;
		end
		case (ready_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	initial begin
		bit [15:0] classic[8];
		bit [15:0] tops[6];
		sb = new();
		classic = '{16'd98, 16'd183, 16'd37, 16'd122, 16'd14, 16'd124, 16'd65, 16'd67};
		tops = '{16'd199, 16'd1, 16'd65535, 16'd1000, 16'd0, 16'd0};
		tops[4] = 16'($urandom_range(1, 65535));
		tops[5] = 16'($urandom_range(2, 300));
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		burst_left = 0;
		steady = 0;
		phase_reqs = 0;
		ready_mode = 0;
		mode_left = 0;
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, top track at its reset value
		send_request(16'd150, 16'd53, 1'b1);
		foreach (classic[i])
			send_request(classic[i], 16'd53, i == 7);
		// overflow batch: head-equal, duplicates at top and zero, clamped tracks
		send_request(16'd100, 16'd100, 1'b0);
		send_request(16'd199, 16'hFFFF, 1'b0);
		send_request(16'd199, 16'd0, 1'b0);
		send_request(16'd0, 16'd0, 1'b0);
		send_request(16'd0, 16'd0, 1'b0);
		send_request(16'd300, 16'd0, 1'b0);
		send_request(16'hFFFF, 16'd0, 1'b0);
		send_request(16'd50, 16'd0, 1'b0);
		send_request(16'd7, 16'd0, 1'b0);
		send_request(16'd8, 16'd0, 1'b1);
		// head beyond the top track
		send_request(16'hFFFF, 16'hFFFF, 1'b1);
		send_request(16'd0, 16'd0, 1'b1);
		wait_idle();

		foreach (tops[p]) begin
			write_top(tops[p]);
			steady = ($urandom_range(0, 3) == 0);
			phase_reqs = 0;
			while (phase_reqs < PHASE_REQS)
				random_batch();
			wait_idle();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
